/* rtl/gsm_pkg.sv */
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared types, command codes and fixed-point constants of the golden-section
// minimizer: controller commands, datapath status and the CORDIC angle table.
// ----------------------------------------------------------------------------
package gsm_pkg;

   localparam int MAX_ITER_DEF     = 64;
   localparam int CORDIC_STEPS_DEF = 24;

   localparam int IDX_W = 5;   // CORDIC step index, up to 32 steps

   // datapath operations
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_MUL_W  = 4'd2;
   localparam logic [3:0] OP_SET_X  = 4'd3;
   localparam logic [3:0] OP_START  = 4'd4;
   localparam logic [3:0] OP_REDUCE = 4'd5;
   localparam logic [3:0] OP_FOLD   = 4'd6;
   localparam logic [3:0] OP_CORDIC = 4'd7;
   localparam logic [3:0] OP_MUL_SQ = 4'd8;
   localparam logic [3:0] OP_P24    = 4'd9;
   localparam logic [3:0] OP_MUL_T1 = 4'd10;
   localparam logic [3:0] OP_T1     = 4'd11;
   localparam logic [3:0] OP_MUL_T2 = 4'd12;
   localparam logic [3:0] OP_FIN    = 4'd13;
   localparam logic [3:0] OP_NARROW = 4'd14;
   localparam logic [3:0] OP_OUT    = 4'd15;

   // point selectors
   localparam logic [1:0] SEL_X1  = 2'd0;
   localparam logic [1:0] SEL_X2  = 2'd1;
   localparam logic [1:0] SEL_MID = 2'd2;

   typedef struct packed {
      logic [3:0]       op;
      logic [1:0]       sel;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic w_gt_tol;     // interval wider than tolerance
      logic k_at_max;     // iteration cap reached
      logic need_reduce;  // angle still outside [-pi, pi]
      logic left_le;      // last narrowing kept the left part
   } status_type;

   localparam logic [31:0] TAU_Q32 = 32'd2654435769;
   localparam logic [31:0] OMT_Q32 = 32'd1640531527;
   localparam logic [30:0] TOL_RESET = 31'd2684355;

   localparam logic signed [33:0] HALF_Q28   = 34'sd134217728;
   localparam logic signed [33:0] TWO_Q28    = 34'sd536870912;
   localparam logic signed [33:0] ONE_Q30    = 34'sd1073741824;
   localparam logic signed [33:0] PI_Q28     = 34'sd843314857;
   localparam logic signed [33:0] HALFPI_Q28 = 34'sd421657428;
   localparam logic signed [33:0] TWOPI_Q28  = 34'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;

   function automatic logic signed [33:0] atan_q30(input logic [IDX_W-1:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0:  r = 34'sd843314856;
         5'd1:  r = 34'sd497837829;
         5'd2:  r = 34'sd263043836;
         5'd3:  r = 34'sd133525158;
         5'd4:  r = 34'sd67021686;
         5'd5:  r = 34'sd33543515;
         5'd6:  r = 34'sd16775850;
         5'd7:  r = 34'sd8388437;
         5'd8:  r = 34'sd4194282;
         5'd9:  r = 34'sd2097149;
         5'd10: r = 34'sd1048575;
         5'd11: r = 34'sd524287;
         5'd12: r = 34'sd262143;
         5'd13: r = 34'sd131071;
         5'd14: r = 34'sd65535;
         5'd15: r = 34'sd32767;
         5'd16: r = 34'sd16383;
         5'd17: r = 34'sd8191;
         5'd18: r = 34'sd4095;
         5'd19: r = 34'sd2047;
         5'd20: r = 34'sd1023;
         5'd21: r = 34'sd511;
         5'd22: r = 34'sd255;
         5'd23: r = 34'sd127;
         5'd24: r = 34'sd63;
         5'd25: r = 34'sd31;
         5'd26: r = 34'sd15;
         5'd27: r = 34'sd7;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/gsm_ctrl.sv */
// ----------------------------------------------------------------------------
// gsm_ctrl
// Sequencer of the search: issues at most one datapath command per cycle and
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module gsm_ctrl
   import gsm_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_INIT   = 5'd1;
   localparam logic [4:0] S_MULW   = 5'd2;
   localparam logic [4:0] S_SETX   = 5'd3;
   localparam logic [4:0] S_EVST   = 5'd4;
   localparam logic [4:0] S_EVRED  = 5'd5;
   localparam logic [4:0] S_EVFOLD = 5'd6;
   localparam logic [4:0] S_EVCORD = 5'd7;
   localparam logic [4:0] S_EVSQ   = 5'd8;
   localparam logic [4:0] S_EVP24  = 5'd9;
   localparam logic [4:0] S_EVMT1  = 5'd10;
   localparam logic [4:0] S_EVT1   = 5'd11;
   localparam logic [4:0] S_EVMT2  = 5'd12;
   localparam logic [4:0] S_EVFIN  = 5'd13;
   localparam logic [4:0] S_LOOP   = 5'd14;
   localparam logic [4:0] S_NARROW = 5'd15;
   localparam logic [4:0] S_PICK   = 5'd16;
   localparam logic [4:0] S_MID    = 5'd17;
   localparam logic [4:0] S_OUT    = 5'd18;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_LOOP   = 2'd2;
   localparam logic [1:0] PH_MID    = 2'd3;

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);

   logic [4:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       sel_ff, sel_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff & ~rsp_ready;
      cmd      = '{op: OP_NONE, sel: sel_ff, idx: cnt_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            phase_in = PH_FIRST;
            sel_in   = SEL_X1;
            state_in = status.w_gt_tol ? S_MULW : S_MID;
         end
         S_MULW: begin
            cmd.op   = OP_MUL_W;
            state_in = S_SETX;
         end
         S_SETX: begin
            cmd.op   = OP_SET_X;
            state_in = S_EVST;
         end
         S_EVST: begin
            cmd.op   = OP_START;
            state_in = S_EVRED;
         end
         S_EVRED: begin
            if (status.need_reduce) begin
               cmd.op = OP_REDUCE;
            end else begin
               state_in = S_EVFOLD;
            end
         end
         S_EVFOLD: begin
            cmd.op   = OP_FOLD;
            cnt_in   = '0;
            state_in = S_EVCORD;
         end
         S_EVCORD: begin
            cmd.op = OP_CORDIC;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = S_EVSQ;
            end
         end
         S_EVSQ: begin
            cmd.op   = OP_MUL_SQ;
            state_in = S_EVP24;
         end
         S_EVP24: begin
            cmd.op   = OP_P24;
            state_in = S_EVMT1;
         end
         S_EVMT1: begin
            cmd.op   = OP_MUL_T1;
            state_in = S_EVT1;
         end
         S_EVT1: begin
            cmd.op   = OP_T1;
            state_in = S_EVMT2;
         end
         S_EVMT2: begin
            cmd.op   = OP_MUL_T2;
            state_in = S_EVFIN;
         end
         S_EVFIN: begin
            cmd.op = OP_FIN;
            unique case (phase_ff)
               PH_FIRST: begin
                  phase_in = PH_SECOND;
                  sel_in   = SEL_X2;
                  state_in = S_MULW;
               end
               PH_SECOND, PH_LOOP: begin
                  phase_in = PH_LOOP;
                  state_in = S_LOOP;
               end
               default: state_in = S_OUT;
            endcase
         end
         S_LOOP: begin
            state_in = (status.w_gt_tol && !status.k_at_max) ? S_NARROW : S_MID;
         end
         S_NARROW: begin
            cmd.op   = OP_NARROW;
            state_in = S_PICK;
         end
         S_PICK: begin
            sel_in   = status.left_le ? SEL_X1 : SEL_X2;
            state_in = S_MULW;
         end
         S_MID: begin
            phase_in = PH_MID;
            sel_in   = SEL_MID;
            state_in = S_EVST;
         end
         S_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.op   = OP_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_FIRST;
         sel_ff   <= SEL_X1;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/gsm_datapath.sv */
// ----------------------------------------------------------------------------
// gsm_datapath
// Search registers, tolerance register, one shared multiplier, the CORDIC
// rotator and the result registers; executes one command per cycle.
// ----------------------------------------------------------------------------
module gsm_datapath
   import gsm_pkg::*;
#(
   parameter int MAX_ITER = MAX_ITER_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   input  logic signed [31:0] req_interval_low,
   input  logic signed [31:0] req_interval_high,
   input  cmd_type            cmd,
   output status_type         status,
   output logic signed [31:0] rsp_final_low,
   output logic signed [31:0] rsp_final_high,
   output logic signed [31:0] rsp_min_point,
   output logic signed [31:0] rsp_min_value,
   output logic [6:0]         rsp_iterations,
   output logic [6:0]         rsp_evaluations,
   output logic               rsp_hit_limit
);

   localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
   localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

   logic [30:0]        tol_ff;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, x1_ff, x1_in, x2_ff, x2_in;
   logic signed [31:0] f1_ff, f1_in, f2_ff, f2_in, fm_ff, fm_in, xe_ff, xe_in;
   logic signed [31:0] p24_ff, p24_in;
   logic signed [33:0] theta_ff, theta_in, cx_ff, cx_in, sy_ff, sy_in, z_ff, z_in;
   logic signed [33:0] t1_ff, t1_in;
   logic               negc_ff, negc_in, le_ff, le_in;
   logic [6:0]         k_ff, k_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [33:0] mul_a, mul_b;

   logic signed [31:0] o_low_ff, o_high_ff, o_mid_ff, o_val_ff;
   logic [6:0]         o_it_ff, o_ev_ff;
   logic               o_hit_ff;

   logic signed [33:0] width, sy_sh, cx_sh, atan_v, q;
   logic signed [67:0] rnd_x, rnd_t1, rnd_t2;
   logic signed [39:0] sq;
   logic signed [40:0] p24_w;
   logic signed [34:0] diff;
   logic signed [32:0] mid_sum;
   logic               dir;

   assign width   = 34'(b_ff) - 34'(a_ff);
   assign mid_sum = 33'(a_ff) + 33'(b_ff);
   assign sy_sh   = sy_ff >>> cmd.idx;
   assign cx_sh   = cx_ff >>> cmd.idx;
   assign atan_v  = atan_q30(cmd.idx);
   assign dir     = ~z_ff[33];
   assign q       = (cx_ff <<< 1) + ONE_Q30;
   assign rnd_x   = (prod_ff + 68'sd2147483648) >>> 32;
   assign sq      = 40'((prod_ff + 68'sd134217728) >>> 28);
   assign p24_w   = (41'(TWO_Q28) - 41'(sq) + 41'sd8) >>> 4;
   assign rnd_t1  = (prod_ff + 68'sd536870912) >>> 30;
   assign rnd_t2  = (prod_ff + 68'sd8589934592) >>> 34;
   assign diff    = 35'(t1_ff) - 35'(rnd_t2);

   assign status.w_gt_tol    = width > $signed({3'b000, tol_ff});
   assign status.k_at_max    = (k_ff == 7'(MAX_ITER));
   assign status.need_reduce = (theta_ff > PI_Q28) || (theta_ff < -PI_Q28);
   assign status.left_le     = le_ff;

   always_comb begin
      a_in = a_ff;   b_in = b_ff;   x1_in = x1_ff; x2_in = x2_ff;
      f1_in = f1_ff; f2_in = f2_ff; fm_in = fm_ff; xe_in = xe_ff;
      p24_in = p24_ff; theta_in = theta_ff; cx_in = cx_ff; sy_in = sy_ff;
      z_in = z_ff;   t1_in = t1_ff; negc_in = negc_ff; le_in = le_ff;
      k_in = k_ff;
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LOAD: begin
            a_in = req_interval_low;
            b_in = req_interval_high;
            k_in = '0;
         end
         OP_MUL_W: begin
            mul_a = width;
            mul_b = $signed({2'b00, (cmd.sel == SEL_X1) ? OMT_Q32 : TAU_Q32});
         end
         OP_SET_X: begin
            if (cmd.sel == SEL_X1) begin
               x1_in = a_ff + rnd_x[31:0];
            end else begin
               x2_in = a_ff + rnd_x[31:0];
            end
         end
         OP_START: begin
            case (cmd.sel)
               SEL_X1:  xe_in = x1_ff;
               SEL_X2:  xe_in = x2_ff;
               default: xe_in = mid_sum[32:1];
            endcase
            theta_in = 34'(xe_in) + HALF_Q28;
         end
         OP_REDUCE: begin
            theta_in = (theta_ff > PI_Q28) ? theta_ff - TWOPI_Q28 : theta_ff + TWOPI_Q28;
         end
         OP_FOLD: begin
            negc_in = 1'b0;
            z_in    = theta_ff <<< 2;
            if (theta_ff > HALFPI_Q28) begin
               negc_in = 1'b1;
               z_in    = (PI_Q28 - theta_ff) <<< 2;
            end else if (theta_ff < -HALFPI_Q28) begin
               negc_in = 1'b1;
               z_in    = (-PI_Q28 - theta_ff) <<< 2;
            end
            cx_in = GAIN_Q30;
            sy_in = '0;
         end
         OP_CORDIC: begin
            cx_in = dir ? cx_ff - sy_sh  : cx_ff + sy_sh;
            sy_in = dir ? sy_ff + cx_sh  : sy_ff - cx_sh;
            z_in  = dir ? z_ff  - atan_v : z_ff  + atan_v;
         end
         OP_MUL_SQ: begin
            mul_a = 34'(xe_ff);
            mul_b = 34'(xe_ff);
            if (negc_ff) begin
               cx_in = -cx_ff;
            end
         end
         OP_P24: p24_in = p24_w[31:0];
         OP_MUL_T1: begin
            mul_a = 34'(p24_ff);
            mul_b = sy_ff;
         end
         OP_T1: t1_in = rnd_t1[33:0];
         OP_MUL_T2: begin
            mul_a = q;
            mul_b = 34'(xe_ff);
         end
         OP_FIN: begin
            logic signed [31:0] f;
            if (diff > SAT_HI) begin
               f = 32'sh7fffffff;
            end else if (diff < SAT_LO) begin
               f = 32'sh80000000;
            end else begin
               f = diff[31:0];
            end
            case (cmd.sel)
               SEL_X1:  f1_in = f;
               SEL_X2:  f2_in = f;
               default: fm_in = f;
            endcase
         end
         OP_NARROW: begin
            le_in = (f1_ff <= f2_ff);
            if (f1_ff <= f2_ff) begin
               b_in  = x2_ff;
               x2_in = x1_ff;
               f2_in = f1_ff;
            end else begin
               a_in  = x1_ff;
               x1_in = x2_ff;
               f1_in = f2_ff;
            end
            k_in = k_ff + 1'b1;
         end
         default: ;
      endcase
      prod_in = 68'(mul_a) * 68'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // search state clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;  b_ff <= '0;  x1_ff <= '0; x2_ff <= '0;
         f1_ff <= '0; f2_ff <= '0; k_ff <= '0;
      end else begin
         a_ff <= a_in;   b_ff <= b_in;   x1_ff <= x1_in; x2_ff <= x2_in;
         f1_ff <= f1_in; f2_ff <= f2_in; k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      fm_ff <= fm_in; xe_ff <= xe_in;
      p24_ff <= p24_in; theta_ff <= theta_in; cx_ff <= cx_in; sy_ff <= sy_in;
      z_ff <= z_in;   t1_ff <= t1_in; negc_ff <= negc_in; le_ff <= le_in;
      prod_ff <= prod_in;
      if (cmd.op == OP_OUT) begin
         o_low_ff  <= a_ff;
         o_high_ff <= b_ff;
         o_mid_ff  <= xe_ff;
         o_val_ff  <= fm_ff;
         o_it_ff   <= k_ff;
         o_ev_ff   <= k_ff + 7'd2;
         o_hit_ff  <= status.w_gt_tol;
      end
   end

   assign rsp_final_low   = o_low_ff;
   assign rsp_final_high  = o_high_ff;
   assign rsp_min_point   = o_mid_ff;
   assign rsp_min_value   = o_val_ff;
   assign rsp_iterations  = o_it_ff;
   assign rsp_evaluations = o_ev_ff;
   assign rsp_hit_limit   = o_hit_ff;

endmodule

/* rtl/golden_section_minimizer.sv */
// ----------------------------------------------------------------------------
// golden_section_minimizer
// Evaluation: each interior point takes the CORDIC rotator steps and four
//   passes through the shared multiplier, with reduction commands while
//   the angle lies outside [-pi, pi].
// Throughput: one interval at a time; a new request is taken once the result
//   register is loaded, while that result still waits.
// Reset: synchronous, active high; clears control and search state and loads
//   tolerance 0.01.
// ----------------------------------------------------------------------------
module golden_section_minimizer
   import gsm_pkg::*;
#(
   parameter int MAX_ITER     = MAX_ITER_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // tolerance register write
   input  logic               csr_wr_en,
   input  logic [30:0]        csr_wr_data,
   // request beat: one search interval
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_interval_low,
   input  logic signed [31:0] req_interval_high,
   // response beat: final interval and minimum
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_final_low,
   output logic signed [31:0] rsp_final_high,
   output logic signed [31:0] rsp_min_point,
   output logic signed [31:0] rsp_min_value,
   output logic [6:0]         rsp_iterations,
   output logic [6:0]         rsp_evaluations,
   output logic               rsp_hit_limit
);

   // Controller issues at most one command a cycle: unless the width is within
   // tolerance, place the two interior points and evaluate each, then narrow and
   // evaluate one new point per step until the width drops to the tolerance or
   // the cap hits; finally evaluate the midpoint and load the response register.
   cmd_type    cmd;
   status_type status;

   gsm_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath holds the interval, interior points, their values and the
   // shared multiplier and CORDIC registers.
   gsm_datapath #(
      .MAX_ITER(MAX_ITER)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .cmd               (cmd),
      .status            (status),
      .rsp_final_low     (rsp_final_low),
      .rsp_final_high    (rsp_final_high),
      .rsp_min_point     (rsp_min_point),
      .rsp_min_value     (rsp_min_value),
      .rsp_iterations    (rsp_iterations),
      .rsp_evaluations   (rsp_evaluations),
      .rsp_hit_limit     (rsp_hit_limit)
   );

endmodule

/* rtl/gsm_checker.sv */
// ----------------------------------------------------------------------------
// gsm_checker
// Port-level checks on the response beat of the golden-section minimizer.
// ----------------------------------------------------------------------------
module gsm_checker #(
   parameter int MAX_ITER = 64
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_final_low,
   input logic signed [31:0] rsp_final_high,
   input logic signed [31:0] rsp_min_point,
   input logic [6:0]         rsp_iterations,
   input logic [6:0]         rsp_evaluations,
   input logic               rsp_hit_limit
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_point))
      else $error("stalled response beat changed");

   a_evals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_evaluations == rsp_iterations + 7'd2)
      else $error("evaluation count mismatch");

   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_limit |-> rsp_iterations == 7'(MAX_ITER))
      else $error("limit flag without full iteration count");

   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_iterations != 7'd0 |->
         rsp_final_low <= rsp_min_point && rsp_min_point <= rsp_final_high)
      else $error("midpoint outside narrowed interval");

endmodule

bind golden_section_minimizer gsm_checker #(.MAX_ITER(MAX_ITER)) u_gsm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_final_low   (rsp_final_low),
   .rsp_final_high  (rsp_final_high),
   .rsp_min_point   (rsp_min_point),
   .rsp_iterations  (rsp_iterations),
   .rsp_evaluations (rsp_evaluations),
   .rsp_hit_limit   (rsp_hit_limit)
);
